// ===== rtl/tempo_synced_wavetable_lfo_macros.svh =====
// Assertion macros for the tempo-synced wavetable LFO.
`ifndef TEMPO_SYNCED_WAVETABLE_LFO_MACROS_SVH
`define TEMPO_SYNCED_WAVETABLE_LFO_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TSWL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define TSWL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define TSWL_ASSERT(lbl, prop, msg)

`define TSWL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/tswl_pkg.sv =====
// Shared types and constants of the tempo-synced wavetable LFO.
package tswl_pkg;

    localparam int DIV_DW    = 30;
    localparam int DIV_LW    = 32;
    localparam int DIV_CW    = 6;
    localparam int MEM_AW    = 16;
    localparam int VAL_W     = 16;

    localparam logic [DIV_CW-1:0] DIV_IT_FBS  = 6'd22;
    localparam logic [DIV_CW-1:0] DIV_IT_SPOS = 6'd32;
    localparam logic [DIV_CW-1:0] DIV_IT_BEAT = 6'd21;

    localparam logic [1:0] CFG_RATE_NUM   = 2'd0;
    localparam logic [1:0] CFG_RATE_DEN   = 2'd1;
    localparam logic [1:0] CFG_FOUR_BAR   = 2'd2;
    localparam logic [1:0] CFG_STEP_COUNT = 2'd3;

    localparam logic [6:0]  RST_RATE_NUM   = 7'd1;
    localparam logic [6:0]  RST_RATE_DEN   = 7'd4;
    localparam logic [23:0] RST_FOUR_BAR   = 24'd384000;
    localparam logic [10:0] RST_STEP_COUNT = 11'd16;

    typedef enum logic [1:0] {
        REQ_WRITE_ENTRY = 2'd0,
        REQ_WRITE_STEP  = 2'd1,
        REQ_READ_SAMPLE = 2'd2,
        REQ_READ_BEAT   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAN,
        ST_RANGE,
        ST_FILL,
        ST_SCYC,
        ST_SMUL,
        ST_SMOD,
        ST_BMUL,
        ST_BMOD,
        ST_IMUL,
        ST_IDIV,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [9:0]        entry_index;
        logic signed [15:0] entry_value;
        logic [31:0]       sample_pos;
        logic [31:0]       beat_pos;
    } t_in;

    typedef struct packed {
        logic signed [15:0] lfo_value;
        logic [9:0]        read_index;
        logic              error;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
        logic [DIV_DW-1:0] rem;
        logic [DIV_LW-1:0] low;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_LW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/tempo_synced_wavetable_lfo.sv =====
// Top level of the tempo-synced wavetable LFO: control sequencer, datapath and ports.
//
//  channel  signals                                  transfer when
//  in       i_in_valid  o_in_ready  i_in_data        i_in_valid & o_in_ready
//  out      o_out_valid i_out_ready o_out_data       o_out_valid & i_out_ready
//  cfg      i_cfg_we    i_cfg_idx   i_cfg_data       i_cfg_we
//
// One item at a time; the shared divider takes one quotient bit a cycle.
// A read with a zero rate, or a sample read with a zero cycle, ends early with error set.
// o_in_ready rises with result valid.
// After reset the table is swept to zero with o_in_ready low.
// A result waiting on the output register holds the next one in its final state.
module tempo_synced_wavetable_lfo #(
    parameter int TABLE_LEN = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tswl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tswl_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);
    import tswl_pkg::*;

    `include "tempo_synced_wavetable_lfo_macros.svh"

    localparam int AW  = $clog2(TABLE_LEN);
    localparam int LW  = $clog2(TABLE_LEN + 1);
    localparam int KW  = (LW > 11) ? LW : 11;
    localparam int IXW = (AW > 10) ? AW : 10;
    localparam int PW  = (DIV_DW + LW > 39) ? DIV_DW + LW : 39;
    localparam logic [LW-1:0] TLV = LW'(TABLE_LEN);

    t_state r_state, n_state;
    logic   r_kick;

    logic [6:0]  r_rate_num;
    logic [6:0]  r_rate_den;
    logic [23:0] r_four_bar;
    logic [10:0] r_step_count;

    logic [LW-1:0]     r_addr;
    logic [LW-1:0]     r_end;
    logic [LW-1:0]     r_span;
    logic [DIV_DW-1:0] r_cyc;
    logic [DIV_DW-1:0] r_rmd;
    logic [PW-1:0]     r_prod;
    logic [AW-1:0]     r_ix;
    t_in               r_item;
    t_out              r_res;

    logic              r_out_valid;
    t_out              r_out_data;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mem_req mem_req;
    logic [15:0] rdata;

    logic              accept;
    logic              bad_rate;
    logic              out_load;
    logic              is_read;
    logic [KW-1:0]     sc_ext;
    logic [LW-1:0]     steps;
    logic [KW-1:0]     last_k;
    logic [KW-1:0]     k_ext;
    logic [AW-1:0]     kc;
    logic              is_last;
    logic [AW+LW-1:0]  prod_a;
    logic [AW+LW-1:0]  prod_b;
    logic [LW-1:0]     fill_end;
    logic              entry_ok;
    logic [28:0]       cyc_mul;
    logic [38:0]       beat_mul;
    logic [IXW-1:0]    ix_ext;

    assign accept   = i_in_valid && o_in_ready;
    assign bad_rate = (r_rate_num == 7'd0) || (r_rate_den == 7'd0);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign is_read  = (i_in_data.req_type == REQ_READ_SAMPLE) ||
                      (i_in_data.req_type == REQ_READ_BEAT);

    always_comb begin
        sc_ext = KW'(r_step_count);
        if (sc_ext == '0) begin
            steps = LW'(1);
        end else if (sc_ext > KW'(TABLE_LEN)) begin
            steps = TLV;
        end else begin
            steps = LW'(sc_ext);
        end
        last_k  = KW'(steps) - KW'(1);
        k_ext   = KW'(r_item.entry_index);
        kc      = (k_ext > last_k) ? AW'(last_k) : AW'(k_ext);
        is_last = (KW'(kc) == last_k);
        prod_a  = (AW+LW)'(kc) * (AW+LW)'(r_span);
        prod_b  = (AW+LW)'(AW'(kc) + AW'(1)) * (AW+LW)'(r_span);
        if (is_last) begin
            fill_end = TLV;
        end else begin
            fill_end = LW'(prod_b);
        end
    end

    assign entry_ok = (KW'(i_in_data.entry_index) < KW'(TABLE_LEN));
    assign cyc_mul  = 29'(r_cyc[21:0]) * 29'(r_rate_num);
    assign beat_mul = 39'(r_item.beat_pos) * 39'(r_rate_den);
    assign ix_ext   = IXW'(r_ix);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == LW'(TABLE_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_in_data.req_type))
                        REQ_WRITE_ENTRY: n_state = ST_DONE;
                        REQ_WRITE_STEP:  n_state = ST_SPAN;
                        REQ_READ_SAMPLE: n_state = bad_rate ? ST_DONE : ST_SCYC;
                        REQ_READ_BEAT:   n_state = bad_rate ? ST_DONE : ST_BMUL;
                        default:         n_state = ST_DONE;
                    endcase
                end
            end
            ST_SPAN:  if (div_rsp.done) n_state = ST_RANGE;
            ST_RANGE: n_state = ST_FILL;
            ST_FILL: begin
                if (r_addr == r_end - LW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCYC:  if (div_rsp.done) n_state = ST_SMUL;
            ST_SMUL:  n_state = (r_cyc == '0) ? ST_DONE : ST_SMOD;
            ST_SMOD:  if (div_rsp.done) n_state = ST_IMUL;
            ST_BMUL:  n_state = ST_BMOD;
            ST_BMOD:  if (div_rsp.done) n_state = ST_IMUL;
            ST_IMUL:  n_state = ST_IDIV;
            ST_IDIV:  if (div_rsp.done) n_state = ST_READ;
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_req = '0;
        unique case (r_state)
            ST_SPAN: begin
                div_req.iters = DIV_CW'(LW);
                div_req.low   = DIV_LW'(TLV) << (DIV_LW - LW);
                div_req.den   = DIV_DW'(steps);
            end
            ST_SCYC: begin
                div_req.iters = DIV_IT_FBS;
                div_req.low   = {r_four_bar[23:2], 10'b0};
                div_req.den   = DIV_DW'(r_rate_den);
            end
            ST_SMOD: begin
                div_req.iters = DIV_IT_SPOS;
                div_req.low   = r_item.sample_pos;
                div_req.den   = r_cyc;
            end
            ST_BMOD: begin
                div_req.iters = DIV_IT_BEAT;
                div_req.rem   = DIV_DW'(r_prod[38:21]);
                div_req.low   = {r_prod[20:0], 11'b0};
                div_req.den   = r_cyc;
            end
            ST_IDIV: begin
                div_req.iters = DIV_CW'(AW);
                div_req.rem   = DIV_DW'(r_prod >> AW);
                div_req.low   = DIV_LW'(r_prod[AW-1:0]) << (DIV_LW - AW);
                div_req.den   = r_cyc;
            end
            default: begin
                div_req = '0;
            end
        endcase
        div_req.start = r_kick && ((r_state == ST_SPAN) || (r_state == ST_SCYC) ||
                        (r_state == ST_SMOD) || (r_state == ST_BMOD) || (r_state == ST_IDIV));
    end

    always_comb begin
        mem_req = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(r_addr);
            end
            ST_IDLE: begin
                mem_req.we    = accept && entry_ok &&
                                (i_in_data.req_type == REQ_WRITE_ENTRY);
                mem_req.waddr = MEM_AW'(i_in_data.entry_index);
                mem_req.wdata = i_in_data.entry_value;
            end
            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(r_addr);
                mem_req.wdata = r_item.entry_value;
            end
            ST_READ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = MEM_AW'(r_ix);
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_kick       <= 1'b0;
            r_addr       <= '0;
            r_out_valid  <= 1'b0;
            r_rate_num   <= RST_RATE_NUM;
            r_rate_den   <= RST_RATE_DEN;
            r_four_bar   <= RST_FOUR_BAR;
            r_step_count <= RST_STEP_COUNT;
        end else begin
            r_state <= n_state;
            r_kick  <= (n_state != r_state);
            if (r_state == ST_CLEAR || r_state == ST_FILL) begin
                r_addr <= r_addr + LW'(1);
            end else if (r_state == ST_RANGE) begin
                r_addr <= LW'(prod_a);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE_NUM:   r_rate_num   <= i_cfg_data[6:0];
                    CFG_RATE_DEN:   r_rate_den   <= i_cfg_data[6:0];
                    CFG_FOUR_BAR:   r_four_bar   <= i_cfg_data;
                    CFG_STEP_COUNT: r_step_count <= i_cfg_data[10:0];
                    default:        r_step_count <= r_step_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
            r_res  <= '{lfo_value: '0, read_index: '0, error: (is_read && bad_rate)};
        end
        unique case (r_state)
            ST_SPAN:  if (div_rsp.done) r_span <= LW'(div_rsp.quo);
            ST_RANGE: r_end <= fill_end;
            ST_SCYC:  if (div_rsp.done) r_cyc <= DIV_DW'(div_rsp.quo);
            ST_SMUL: begin
                r_cyc <= DIV_DW'(cyc_mul);
                if (r_cyc == '0) begin
                    r_res.error <= 1'b1;
                end
            end
            ST_SMOD:  if (div_rsp.done) r_rmd <= div_rsp.rem;
            ST_BMUL: begin
                r_prod <= PW'(beat_mul);
                r_cyc  <= DIV_DW'({r_rate_num, 18'b0});
            end
            ST_BMOD:  if (div_rsp.done) r_rmd <= div_rsp.rem;
            ST_IMUL:  r_prod <= PW'(PW'(r_rmd) * PW'(TABLE_LEN));
            ST_IDIV:  if (div_rsp.done) r_ix <= AW'(div_rsp.quo);
            ST_RDATA: begin
                r_res.lfo_value  <= rdata;
                r_res.read_index <= ix_ext[9:0];
            end
            default: begin
                r_ix <= r_ix;
            end
        endcase
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    tswl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tswl_wtab #(
        .TABLE_LEN (TABLE_LEN)
    ) u_wtab (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TSWL_ASSERT(a_accept_leaves_idle, (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE), "accepted item did not start")
    `TSWL_ASSERT(a_div_done_in_div_state, div_rsp.done |-> ((r_state == ST_SPAN) || (r_state == ST_SCYC) || (r_state == ST_SMOD) || (r_state == ST_BMOD) || (r_state == ST_IDIV)), "divider result outside a divide state")
    `TSWL_ASSERT(a_fill_in_range, (r_state == ST_FILL) |-> (r_addr < r_end), "step fill past its end")
    `TSWL_ASSERT(a_error_result_zero, (o_out_valid && o_out_data.error) |-> ((o_out_data.lfo_value == 16'sd0) && (o_out_data.read_index == 10'd0)), "error result carries data")

endmodule

// ===== rtl/tswl_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preloaded partial remainder.
module tswl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tswl_pkg::t_div_req i_req,
    output tswl_pkg::t_div_rsp o_rsp
);
    import tswl_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_LW-1:0] r_low;
    logic [DIV_LW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   cand;
    logic              ge;

    assign cand = {r_rem, r_low[DIV_LW-1]};
    assign ge   = (cand >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_DW'(cand - {1'b0, r_den}) : DIV_DW'(cand);
            r_low <= r_low << 1;
            r_quo <= {r_quo[DIV_LW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/tswl_wtab.sv =====
// Wave table memory: one write port, one registered read port.
module tswl_wtab #(
    parameter int TABLE_LEN = 1024
) (
    input  logic              i_clk,
    input  tswl_pkg::t_mem_req i_req,
    output logic [15:0]       o_rdata
);
    import tswl_pkg::*;

    localparam int AW = $clog2(TABLE_LEN);

    logic [VAL_W-1:0] mem [TABLE_LEN];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule
